### src/ppt_pkg.sv
// Shared types, constants and register codes of the plane-to-plane point transform.
`default_nettype none

package ppt_pkg;

	// Field formats.
	localparam int COORD_WIDTH = 20;
	localparam int NORM_WIDTH  = 16;
	localparam int POINT_REG_W = 3 * COORD_WIDTH;
	localparam int NORM_REG_W  = 3 * NORM_WIDTH;

	// Configuration port.
	localparam int CFG_DATA_W = POINT_REG_W;
	localparam int CFG_IDX_W  = 2;

	// Internal widths: point minus plane point, axis components, dot product and 1+c.
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int AXIS_W = 2 * NORM_WIDTH;
	localparam int DOT_W  = 2 * NORM_WIDTH + 2;
	// Normal products carry this many fraction bits.
	localparam int PROD_FRAC = 2 * NORM_WIDTH - 2;
	// Quotient bits kept before the quotient is clipped; beyond this the output saturates anyway.
	localparam int QUO_W = COORD_WIDTH + 5;

	// Queue depths.
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	// Register reset values: normals point along +z.
	localparam logic [NORM_REG_W-1:0] NORM_RESET = 48'h7FFF_0000_0000;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SRC_POINT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SRC_NORMAL = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DST_POINT  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_DST_NORMAL = CFG_IDX_W'(3);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t in_x;
		coord_t in_y;
		coord_t in_z;
	} in_item_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		logic   saturated;
	} out_item_t;

	typedef logic [2:0][DIFF_W-1:0]      diff3_t;
	typedef logic [2:0][COORD_WIDTH-1:0] coord3_t;

	// Rotation terms derived from the two normals, plus the destination point.
	typedef struct packed {
		logic [2:0][AXIS_W-1:0] axis;
		logic [DOT_W-1:0]       dot;
		logic [DOT_W-1:0]       denom;
		logic                   zero_axis;
		logic                   denom_clip;
		coord3_t                dst;
	} xform_t;

endpackage

`default_nettype wire

### src/ppt_fifo.sv
// Small register-based queue used between the front and back parts and at the output.
`default_nettype none

module ppt_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic         pop,
	input  logic [W-1:0] wdata,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

### src/ppt_cfg.sv
// Configuration registers and the rotation terms derived from the two plane normals.
`default_nettype none

module ppt_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [ppt_pkg::CFG_DATA_W-1:0]  wr_data,
	output ppt_pkg::coord3_t                src,
	output ppt_pkg::xform_t                 xf,
	output logic                            busy
);
	import ppt_pkg::*;

	localparam int PROD_W = 2 * NORM_WIDTH;
	localparam logic [1:0] SETTLE = 2'd3;
	localparam logic signed [DOT_W-1:0] ONE_SCALED = DOT_W'(64'sd1 <<< PROD_FRAC);

	logic [POINT_REG_W-1:0]   src_pt_q;
	logic [POINT_REG_W-1:0]   dst_pt_q;
	logic [NORM_REG_W-1:0]    src_nrm_q;
	logic [NORM_REG_W-1:0]    dst_nrm_q;
	logic [1:0]               settle_q;

	logic signed [PROD_W-1:0] prod_s1 [3][3];

	logic [2:0][AXIS_W-1:0]   axis_d;
	logic signed [DOT_W-1:0]  dot_d;
	logic signed [DOT_W-1:0]  denom_d;
	logic                     clip_d;
	logic                     zero_d;

	logic [2:0][AXIS_W-1:0]   axis_s2;
	logic [DOT_W-1:0]         dot_s2;
	logic [DOT_W-1:0]         denom_s2;
	logic                     clip_s2;
	logic                     zero_s2;

	// Register writes; every write restarts the settle count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_pt_q  <= '0;
			dst_pt_q  <= '0;
			src_nrm_q <= NORM_RESET;
			dst_nrm_q <= NORM_RESET;
			settle_q  <= SETTLE;
		end else begin
			if (wr_en) begin
				settle_q <= SETTLE;
				case (wr_index)
					REG_SRC_POINT:  src_pt_q  <= wr_data[POINT_REG_W-1:0];
					REG_SRC_NORMAL: src_nrm_q <= wr_data[NORM_REG_W-1:0];
					REG_DST_POINT:  dst_pt_q  <= wr_data[POINT_REG_W-1:0];
					REG_DST_NORMAL: dst_nrm_q <= wr_data[NORM_REG_W-1:0];
					default: ;
				endcase
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	assign busy = (settle_q != 2'd0);

	// All nine products of source and destination normal components.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s1[i][j] <= $signed(src_nrm_q[i*NORM_WIDTH +: NORM_WIDTH])
					* $signed(dst_nrm_q[j*NORM_WIDTH +: NORM_WIDTH]);
			end
		end
	end

	// Cross product axis, dot product, and 1+c with its clip to one.
	always_comb begin
		axis_d[0] = prod_s1[1][2] - prod_s1[2][1];
		axis_d[1] = prod_s1[2][0] - prod_s1[0][2];
		axis_d[2] = prod_s1[0][1] - prod_s1[1][0];
		dot_d     = DOT_W'(prod_s1[0][0]) + DOT_W'(prod_s1[1][1]) + DOT_W'(prod_s1[2][2]);
		denom_d   = dot_d + ONE_SCALED;
		clip_d    = denom_d[DOT_W-1] || (denom_d == '0);
		zero_d    = (prod_s1[1][2] == prod_s1[2][1]) && (prod_s1[2][0] == prod_s1[0][2])
			&& (prod_s1[0][1] == prod_s1[1][0]);
	end

	always_ff @(posedge clk) begin
		axis_s2  <= axis_d;
		dot_s2   <= dot_d;
		denom_s2 <= clip_d ? DOT_W'(1) : denom_d;
		clip_s2  <= clip_d;
		zero_s2  <= zero_d;
	end

	// Unpacked points and the derived terms.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			src[i]    = src_pt_q[i*COORD_WIDTH +: COORD_WIDTH];
			xf.dst[i] = dst_pt_q[i*COORD_WIDTH +: COORD_WIDTH];
		end
		xf.axis       = axis_s2;
		xf.dot        = dot_s2;
		xf.denom      = denom_s2;
		xf.zero_axis  = zero_s2;
		xf.denom_clip = clip_s2;
	end

endmodule

`default_nettype wire

### src/ppt_front.sv
// Front part: accepts points, subtracts the source plane point and hands them to the queue.
`default_nettype none

module ppt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  ppt_pkg::in_item_t  in_item,
	input  logic               busy,
	input  ppt_pkg::coord3_t   src,
	input  logic               mq_full,
	output logic               mq_push,
	output ppt_pkg::diff3_t    mq_data
);
	import ppt_pkg::*;

	coord3_t pt;
	diff3_t  diff_s1;
	logic    vld_s1;
	logic    accept;

	assign pt[0] = in_item.in_x;
	assign pt[1] = in_item.in_y;
	assign pt[2] = in_item.in_z;

	// Stall while the derived terms settle or while the held point cannot move on.
	assign full    = busy || (vld_s1 && mq_full);
	assign accept  = push && !full;
	assign mq_push = vld_s1 && !mq_full;
	assign mq_data = diff_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (mq_push) begin
			vld_s1 <= 1'b0;
		end
	end

	// Offset from the source plane point, one bit wider than a coordinate.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++) begin
				diff_s1[i] <= DIFF_W'($signed(pt[i])) - DIFF_W'($signed(src[i]));
			end
		end
	end

endmodule

`default_nettype wire

### src/ppt_back.sv
// Back part: rotation arithmetic, pipelined quotient unit and output saturation.
`default_nettype none

module ppt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ppt_pkg::xform_t    xf,
	input  logic               mq_empty,
	input  ppt_pkg::diff3_t    mq_data,
	output logic               mq_pop,
	input  logic               oq_full,
	output logic               oq_push,
	output ppt_pkg::out_item_t oq_data
);
	import ppt_pkg::*;

	localparam int AVW  = AXIS_W + DIFF_W;
	localparam int CVW  = DOT_W + DIFF_W;
	localparam int SW   = CVW + 1;
	localparam int RTW  = SW - PROD_FRAC;
	localparam int NPW  = AXIS_W + RTW;
	localparam int QB   = QUO_W;
	localparam int HIW  = NPW - QB;
	localparam int REMW = DOT_W + 1;
	localparam int QSW  = QB + 2;
	localparam int OW   = COORD_WIDTH + 9;
	localparam logic signed [SW-1:0] RND_HALF = SW'(64'sd1 <<< (PROD_FRAC - 1));
	localparam logic signed [OW-1:0] OMAX = OW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
	localparam logic signed [OW-1:0] OMIN = ~OMAX;

	typedef struct packed {
		logic [REMW-1:0] rem;
		logic [QB-1:0]   lo;
		logic [QB-1:0]   quo;
		logic            neg;
		logic            huge;
	} lane_t;

	typedef struct packed {
		lane_t [2:0]         ln;
		diff3_t              v;
		logic [2:0][RTW-1:0] rt;
	} dstage_t;

	logic                  en;

	// Stage 1: products with the axis and the dot product.
	logic                  vld_s1;
	diff3_t                v_s1;
	logic signed [AVW-1:0] av_s1 [3][3];
	logic signed [CVW-1:0] cv_s1 [3];

	// Stage 2: a.v and c*v + a x v.
	logic                  vld_s2;
	diff3_t                v_s2;
	logic signed [SW-1:0]  t_s2;
	logic signed [SW-1:0]  sum_s2 [3];
	logic signed [SW-1:0]  axv_d [3];

	// Stage 3: rounded to coordinate scale.
	logic                  vld_s3;
	diff3_t                v_s3;
	logic signed [RTW-1:0] tq_s3;
	logic [2:0][RTW-1:0]   rt_s3;
	logic signed [SW-1:0]  t_rnd;
	logic signed [SW-1:0]  s_rnd [3];

	// Stage 4: numerators a_i * tq.
	logic                  vld_s4;
	diff3_t                v_s4;
	logic [2:0][RTW-1:0]   rt_s4;
	logic signed [NPW-1:0] n_s4 [3];

	// Stage 5 onward: one quotient bit per stage.
	logic [QB:0]           dvld_q;
	dstage_t               div_s5 [QB+1];
	dstage_t               div_nxt [QB+1];

	// Output register.
	logic                  res_vld_q;
	out_item_t             res_q;
	out_item_t             res_d;

	// The whole pipeline moves unless a finished result is blocked by the output queue.
	assign en      = !res_vld_q || !oq_full;
	assign mq_pop  = en && !mq_empty;
	assign oq_push = res_vld_q && !oq_full;
	assign oq_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			dvld_q    <= '0;
			res_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= !mq_empty;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			dvld_q    <= {dvld_q[QB-1:0], vld_s4};
			res_vld_q <= dvld_q[QB];
		end
	end

	// Stage 1 products.
	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= mq_data;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					av_s1[i][j] <= AVW'($signed(xf.axis[i])) * AVW'($signed(mq_data[j]));
				end
				cv_s1[i] <= CVW'($signed(xf.dot)) * CVW'($signed(mq_data[i]));
			end
		end
	end

	// Stage 2 sums.
	always_comb begin
		axv_d[0] = SW'(av_s1[1][2]) - SW'(av_s1[2][1]);
		axv_d[1] = SW'(av_s1[2][0]) - SW'(av_s1[0][2]);
		axv_d[2] = SW'(av_s1[0][1]) - SW'(av_s1[1][0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s2 <= v_s1;
			t_s2 <= SW'(av_s1[0][0]) + SW'(av_s1[1][1]) + SW'(av_s1[2][2]);
			for (int i = 0; i < 3; i++) begin
				sum_s2[i] <= SW'(cv_s1[i]) + axv_d[i];
			end
		end
	end

	// Stage 3: round half up, then floor shift to coordinate scale.
	always_comb begin
		t_rnd = t_s2 + RND_HALF;
		for (int i = 0; i < 3; i++) begin
			s_rnd[i] = sum_s2[i] + RND_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s3  <= v_s2;
			tq_s3 <= t_rnd[SW-1:PROD_FRAC];
			for (int i = 0; i < 3; i++) begin
				rt_s3[i] <= s_rnd[i][SW-1:PROD_FRAC];
			end
		end
	end

	// Stage 4 numerators.
	always_ff @(posedge clk) begin
		if (en) begin
			v_s4  <= v_s3;
			rt_s4 <= rt_s3;
			for (int i = 0; i < 3; i++) begin
				n_s4[i] <= NPW'($signed(xf.axis[i])) * NPW'(tq_s3);
			end
		end
	end

	// Quotient unit: sign and magnitude split, overflow check, then restoring steps.
	always_comb begin
		logic [NPW-1:0]  mag;
		logic [HIW-1:0]  hi;
		logic            big;
		logic [REMW-1:0] rem2;
		logic [REMW-1:0] dvs;
		int              b;
		dvs = REMW'(xf.denom);
		div_nxt[0].v  = v_s4;
		div_nxt[0].rt = rt_s4;
		for (int i = 0; i < 3; i++) begin
			mag = n_s4[i][NPW-1] ? NPW'(-n_s4[i]) : NPW'(n_s4[i]);
			hi  = mag[NPW-1:QB];
			big = (REMW'(hi) >= dvs);
			div_nxt[0].ln[i].neg  = n_s4[i][NPW-1];
			div_nxt[0].ln[i].huge = big;
			div_nxt[0].ln[i].rem  = big ? '0 : REMW'(hi);
			div_nxt[0].ln[i].lo   = mag[QB-1:0];
			div_nxt[0].ln[i].quo  = '0;
		end
		for (int k = 0; k < QB; k++) begin
			b = QB - 1 - k;
			div_nxt[k+1] = div_s5[k];
			for (int i = 0; i < 3; i++) begin
				rem2 = {div_s5[k].ln[i].rem[REMW-2:0], div_s5[k].ln[i].lo[b]};
				if (rem2 >= dvs) begin
					div_nxt[k+1].ln[i].rem    = rem2 - dvs;
					div_nxt[k+1].ln[i].quo[b] = 1'b1;
				end else begin
					div_nxt[k+1].ln[i].rem = rem2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s5 <= div_nxt;
		end
	end

	// Final sum, destination offset and saturation.
	always_comb begin
		logic [QSW-1:0]        qmag;
		logic signed [QSW-1:0] qs;
		logic signed [OW-1:0]  rsum;
		logic signed [OW-1:0]  osum;
		coord3_t               oc;
		logic                  sat;
		sat = !xf.zero_axis && xf.denom_clip;
		for (int i = 0; i < 3; i++) begin
			qmag = div_s5[QB].ln[i].huge ? (QSW'(1) << QB) : QSW'(div_s5[QB].ln[i].quo);
			qs   = div_s5[QB].ln[i].neg ? -qmag : qmag;
			rsum = OW'($signed(div_s5[QB].rt[i])) + OW'(qs);
			if (xf.zero_axis) begin
				rsum = OW'($signed(div_s5[QB].v[i]));
			end
			osum = rsum + OW'($signed(xf.dst[i]));
			if (osum > OMAX) begin
				oc[i] = OMAX[COORD_WIDTH-1:0];
				sat   = 1'b1;
			end else if (osum < OMIN) begin
				oc[i] = OMIN[COORD_WIDTH-1:0];
				sat   = 1'b1;
			end else begin
				oc[i] = osum[COORD_WIDTH-1:0];
			end
		end
		res_d.out_x     = oc[0];
		res_d.out_y     = oc[1];
		res_d.out_z     = oc[2];
		res_d.saturated = sat;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

### src/plane_to_plane_point_transform_core.sv
// Top level of the plane-to-plane point transform.
//
// Channel   Direction  Handshake               Transaction
// in_item   in         push / full             point x, y, z (Q8.12)
// out_item  out        empty / pop             point x, y, z and saturated flag
// wr_*      in         wr_en, no wait          one configuration register write
//
// One point per cycle is sustained while the rotation terms are not settling and
// the output queue takes results; the quotient unit works one bit per stage (25 stages).
// After reset and after every register write, full stays high while the
// rotation terms are recomputed from the normals.
// A stalled output holds the back pipeline; the front keeps taking points
// until the middle queue fills.
`default_nettype none

module plane_to_plane_point_transform_core #(
	parameter int MID_DEPTH = ppt_pkg::MID_DEPTH,
	parameter int OUT_DEPTH = ppt_pkg::OUT_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  ppt_pkg::in_item_t              in_item,
	output logic                           empty,
	input  logic                           pop,
	output ppt_pkg::out_item_t             out_item,
	input  logic                           wr_en,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [ppt_pkg::CFG_DATA_W-1:0] wr_data
);
	import ppt_pkg::*;

	coord3_t   src;
	xform_t    xf;
	logic      busy;
	logic      mq_push;
	logic      mq_pop;
	logic      mq_full;
	logic      mq_empty;
	diff3_t    mq_wdata;
	diff3_t    mq_rdata;
	logic      oq_push;
	logic      oq_full;
	out_item_t oq_wdata;

	// Configuration registers and derived rotation terms.
	ppt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.src      (src),
		.xf       (xf),
		.busy     (busy)
	);

	// Input side.
	ppt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_item (in_item),
		.busy    (busy),
		.src     (src),
		.mq_full (mq_full),
		.mq_push (mq_push),
		.mq_data (mq_wdata)
	);

	// Queue between front and back.
	ppt_fifo #(
		.W     ($bits(diff3_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mq_push),
		.pop    (mq_pop),
		.wdata  (mq_wdata),
		.rdata  (mq_rdata),
		.full   (mq_full),
		.empty  (mq_empty)
	);

	// Arithmetic pipeline.
	ppt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.xf       (xf),
		.mq_empty (mq_empty),
		.mq_data  (mq_rdata),
		.mq_pop   (mq_pop),
		.oq_full  (oq_full),
		.oq_push  (oq_push),
		.oq_data  (oq_wdata)
	);

	// Result queue.
	ppt_fifo #(
		.W     ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.pop    (pop),
		.wdata  (oq_wdata),
		.rdata  (out_item),
		.full   (oq_full),
		.empty  (empty)
	);

`ifndef NO_ASSERTIONS
	// A register write must block new points while the derived terms settle.
	a_write_blocks : assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> full) else $error("point accepted right after a register write");

	// The front never drops a point into a full middle queue.
	a_mid_push : assert property (@(posedge clk) disable iff (!arst_n)
		mq_push |-> !mq_full) else $error("push into full middle queue");

	// The back never takes from an empty middle queue.
	a_mid_pop : assert property (@(posedge clk) disable iff (!arst_n)
		mq_pop |-> !mq_empty) else $error("pop from empty middle queue");

	// The back never overfills the result queue.
	a_out_push : assert property (@(posedge clk) disable iff (!arst_n)
		oq_push |-> !oq_full) else $error("push into full result queue");
`endif

endmodule

`default_nettype wire
